// File: sv/gra_pkg.sv
package gra_pkg;

    // averaging window is 2^AVG_SHIFT samples
    localparam int AVG_SHIFT  = 9;
    // counter value that ends the skip window while on the pad
    localparam int HOLD_COUNT = 1024;

    localparam int SUM_COUNT = 1 << AVG_SHIFT;
    localparam int CNT_MAX   = (HOLD_COUNT > SUM_COUNT) ? HOLD_COUNT : SUM_COUNT;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);

    // field widths
    localparam int PRES_W = 24;
    localparam int SMP_W  = 16;
    localparam int RATE_W = 25;

    // accumulator widths, sized so they never overflow
    localparam int P_ACC_W = PRES_W + AVG_SHIFT;
    localparam int A_ACC_W = SMP_W + AVG_SHIFT;
    localparam int SAT_W   = (A_ACC_W > RATE_W) ? A_ACC_W : RATE_W;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 25'sh0FFFFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 25'sh1000000;

    // one sensor sample
    typedef struct packed {
        logic [PRES_W-1:0]           pressure;
        logic [3:0][SMP_W-1:0]       accel;    // axial, along, across, through
        logic [2:0][SMP_W-1:0]       rate;     // pitch, yaw, roll
        logic                        on_pad;
    } sample_t;

    // input stage contents
    typedef struct packed {
        logic    vld;
        sample_t smp;
    } in_stage_t;

    // one result
    typedef struct packed {
        logic                        ready_res;
        logic                        refs_updated;
        logic [PRES_W-1:0]           ground_pressure;
        logic [3:0][SMP_W-1:0]       ground_accel;
        logic [2:0][RATE_W-1:0]      ground_rate;
    } result_t;

    // clamp a rate sum into the 25-bit reference range
    function automatic logic [RATE_W-1:0] sat_rate(input logic signed [A_ACC_W-1:0] s);
        logic signed [SAT_W-1:0] w;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        w  = SAT_W'(s);
        hi = SAT_W'(RATE_MAX);
        lo = SAT_W'(RATE_MIN);
        if (w > hi) begin
            w = hi;
        end else if (w < lo) begin
            w = lo;
        end
        return RATE_W'(w);
    endfunction

endpackage

// File: sv/gra_in_reg.sv
module gra_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  gra_pkg::sample_t     s_smp,
    input  logic                 advance,
    output logic                 s_ready,
    output gra_pkg::in_stage_t   stage
);

    logic             vld_reg;
    logic             vld_next;
    gra_pkg::sample_t smp_reg;

    // take a new request when empty or when the held one moves on
    assign s_ready  = !vld_reg || advance;
    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            smp_reg <= s_smp;
        end
    end

    assign stage.vld = vld_reg;
    assign stage.smp = smp_reg;

endmodule

// File: sv/gra_core.sv
module gra_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  gra_pkg::sample_t   smp,
    output gra_pkg::result_t   res
);

    localparam logic [gra_pkg::CNT_W-1:0] SUM_C  = gra_pkg::CNT_W'(gra_pkg::SUM_COUNT);
    localparam logic [gra_pkg::CNT_W-1:0] HOLD_C = gra_pkg::CNT_W'(gra_pkg::HOLD_COUNT);
    localparam logic [gra_pkg::CNT_W-1:0] MAX_C  = gra_pkg::CNT_W'(gra_pkg::CNT_MAX);

    logic [gra_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                               startup_reg, startup_next;
    logic [gra_pkg::P_ACC_W-1:0]        p_acc_reg, p_acc_next;
    logic signed [gra_pkg::A_ACC_W-1:0] a_acc_reg [4];
    logic signed [gra_pkg::A_ACC_W-1:0] a_acc_next [4];
    logic signed [gra_pkg::A_ACC_W-1:0] r_acc_reg [3];
    logic signed [gra_pkg::A_ACC_W-1:0] r_acc_next [3];
    logic [gra_pkg::PRES_W-1:0]         gp_reg, gp_next;
    logic [3:0][gra_pkg::SMP_W-1:0]     ga_reg, ga_next;
    logic [2:0][gra_pkg::RATE_W-1:0]    gr_reg, gr_next;
    logic                               add_smp;
    logic                               latch;
    logic                               count_only;

    // decide what this sample does
    always_comb begin
        add_smp    = 1'b0;
        latch      = 1'b0;
        count_only = 1'b0;
        if (fire && (startup_reg || smp.on_pad)) begin
            if (cnt_reg < SUM_C) begin
                add_smp = 1'b1;
            end else if (!startup_reg && (cnt_reg < HOLD_C)) begin
                count_only = 1'b1;
            end else begin
                latch = 1'b1;
            end
        end
    end

    // accumulate, or latch the references and clear the sums
    always_comb begin
        cnt_next     = cnt_reg;
        startup_next = startup_reg;
        p_acc_next   = p_acc_reg;
        gp_next      = gp_reg;
        ga_next      = ga_reg;
        gr_next      = gr_reg;
        for (int i = 0; i < 4; i++) begin
            a_acc_next[i] = a_acc_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            r_acc_next[i] = r_acc_reg[i];
        end
        if (add_smp) begin
            cnt_next   = gra_pkg::CNT_W'(cnt_reg + 1'b1);
            p_acc_next = p_acc_reg + gra_pkg::P_ACC_W'(smp.pressure);
            for (int i = 0; i < 4; i++) begin
                a_acc_next[i] = a_acc_reg[i]
                              + gra_pkg::A_ACC_W'($signed(smp.accel[i]));
            end
            for (int i = 0; i < 3; i++) begin
                r_acc_next[i] = r_acc_reg[i]
                              + gra_pkg::A_ACC_W'($signed(smp.rate[i]));
            end
        end else if (count_only) begin
            cnt_next = gra_pkg::CNT_W'(cnt_reg + 1'b1);
        end else if (latch) begin
            cnt_next     = '0;
            startup_next = 1'b0;
            p_acc_next   = '0;
            gp_next      = gra_pkg::PRES_W'(p_acc_reg >> gra_pkg::AVG_SHIFT);
            for (int i = 0; i < 4; i++) begin
                // arithmetic shift rounds toward minus infinity
                ga_next[i]    = gra_pkg::SMP_W'(a_acc_reg[i] >>> gra_pkg::AVG_SHIFT);
                a_acc_next[i] = '0;
            end
            for (int i = 0; i < 3; i++) begin
                gr_next[i]    = gra_pkg::sat_rate(r_acc_reg[i]);
                r_acc_next[i] = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            startup_reg <= 1'b1;
            p_acc_reg   <= '0;
            gp_reg      <= '0;
            ga_reg      <= '0;
            gr_reg      <= '0;
            for (int i = 0; i < 4; i++) begin
                a_acc_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_acc_reg[i] <= '0;
            end
        end else begin
            cnt_reg     <= cnt_next;
            startup_reg <= startup_next;
            p_acc_reg   <= p_acc_next;
            gp_reg      <= gp_next;
            ga_reg      <= ga_next;
            gr_reg      <= gr_next;
            for (int i = 0; i < 4; i++) begin
                a_acc_reg[i] <= a_acc_next[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_acc_reg[i] <= r_acc_next[i];
            end
        end
    end

    // result reflects the state after this sample
    assign res.ready_res       = !startup_next;
    assign res.refs_updated    = latch;
    assign res.ground_pressure = gp_next;
    assign res.ground_accel    = ga_next;
    assign res.ground_rate     = gr_next;

`ifndef SYNTHESIS
    // startup mode is left once and never re-entered
    a_startup_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !startup_reg |=> !startup_reg)
        else $error("startup mode re-entered");

    // counter stays within its window
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_C)
        else $error("sample counter out of range");

    // a latch restarts the count and clears the pressure sum
    a_latch_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        latch |=> (cnt_reg == '0) && (p_acc_reg == '0) && !startup_reg)
        else $error("latch did not restart averaging");

    // no state moves without a request
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(cnt_reg) && $stable(gp_reg))
        else $error("state changed without a request");
`endif

endmodule

// File: sv/gra_out_reg.sv
module gra_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  gra_pkg::result_t   res,
    input  logic               m_ready,
    output logic               advance,
    output logic               m_valid,
    output gra_pkg::result_t   m_res
);

    logic             vld_reg;
    logic             vld_next;
    gra_pkg::result_t res_reg;

    // register can load when empty or being drained
    assign advance  = !vld_reg || m_ready;
    assign vld_next = advance ? fire : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_valid = vld_reg;
    assign m_res   = res_reg;

endmodule

// File: sv/ground_reference_averager_top.sv
// path: a request waits in the input stage register, then the core processes it
// into the result register that drives m_tvalid; throughput: one sample per cycle
// unless m_tready stalls the output, set by the single-pass accumulate/latch step
// reset: aresetn synchronous active low; clears sums, counter and references,
// enters startup averaging and empties both stage registers
module ground_reference_averager_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // pressure[23:0], accel_axial, accel_along, accel_across, accel_through,
    // rate_pitch, rate_yaw, rate_roll (16 bits each)
    input  logic [135:0]   s_tdata,
    // on_pad
    input  logic [0:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    // ground_pressure[23:0], ground_accel, ground_along, ground_across,
    // ground_through (16 bits each), ground_pitch_sum, ground_yaw_sum,
    // ground_roll_sum (25 bits each), zero fill [167:163]
    output logic [167:0]   m_tdata,
    // ready_res, refs_updated
    output logic [1:0]     m_tuser
);

    gra_pkg::sample_t   s_smp;
    gra_pkg::in_stage_t stage;
    gra_pkg::result_t   core_res;
    gra_pkg::result_t   out_res;
    logic               advance;
    logic               fire;

    // unpack the request
    assign s_smp.pressure = s_tdata[23:0];
    assign s_smp.accel[0] = s_tdata[39:24];
    assign s_smp.accel[1] = s_tdata[55:40];
    assign s_smp.accel[2] = s_tdata[71:56];
    assign s_smp.accel[3] = s_tdata[87:72];
    assign s_smp.rate[0]  = s_tdata[103:88];
    assign s_smp.rate[1]  = s_tdata[119:104];
    assign s_smp.rate[2]  = s_tdata[135:120];
    assign s_smp.on_pad   = s_tuser[0];

    gra_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_smp   (s_smp),
        .advance (advance),
        .s_ready (s_tready),
        .stage   (stage)
    );

    // held sample is processed when the result register can take it
    assign fire = stage.vld && advance;

    gra_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .smp     (stage.smp),
        .res     (core_res)
    );

    gra_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .res     (core_res),
        .m_ready (m_tready),
        .advance (advance),
        .m_valid (m_tvalid),
        .m_res   (out_res)
    );

    // pack the result
    assign m_tuser[0]        = out_res.ready_res;
    assign m_tuser[1]        = out_res.refs_updated;
    assign m_tdata[23:0]     = out_res.ground_pressure;
    assign m_tdata[39:24]    = out_res.ground_accel[0];
    assign m_tdata[55:40]    = out_res.ground_accel[1];
    assign m_tdata[71:56]    = out_res.ground_accel[2];
    assign m_tdata[87:72]    = out_res.ground_accel[3];
    assign m_tdata[112:88]   = out_res.ground_rate[0];
    assign m_tdata[137:113]  = out_res.ground_rate[1];
    assign m_tdata[162:138]  = out_res.ground_rate[2];
    assign m_tdata[167:163]  = '0;

endmodule

// File: verif/tb_top.sv
module tb_top;

    // one sensor sample as sent to the block
    typedef struct packed {
        bit [23:0]      pressure;
        bit [3:0][15:0] accel;    // axial, along, across, through
        bit [2:0][15:0] rate;     // pitch, yaw, roll
        bit             on_pad;
    } sensor_sample_t;

    // ground references the block should report for one request
    typedef struct packed {
        bit             started;
        bit             updated;
        bit [23:0]      pressure;
        bit [3:0][15:0] accel;
        bit [2:0][24:0] rate;
    } ground_refs_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic [1:0]   m_tuser;

    ground_reference_averager_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // averaging state mirrored on the testbench side
    int unsigned  avg_count   = 0;
    bit           in_startup  = 1'b1;
    longint       pres_sum    = 0;
    longint       accel_sum [4];
    longint       rate_sum  [3];
    ground_refs_t held_refs   = '0;
    int           latch_total = 0;
    ground_refs_t refs_q [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_off_req = 0;
    int err_count    = 0;

    string accel_name [4] = '{"ground_accel", "ground_along", "ground_across",
                              "ground_through"};
    string rate_name  [3] = '{"ground_pitch_sum", "ground_yaw_sum", "ground_roll_sum"};

    // advance the averaging state by one sample and return the references it shows
    function automatic ground_refs_t predict_refs(input sensor_sample_t smp);
        ground_refs_t r;
        longint       clamped;
        bit           latch;
        latch = 1'b0;
        // startup runs whatever on_pad says, later only while on the pad
        if (in_startup || smp.on_pad) begin
            if (avg_count < gra_pkg::SUM_COUNT) begin
                pres_sum += longint'(smp.pressure);
                for (int i = 0; i < 4; i++) begin
                    accel_sum[i] += longint'($signed(smp.accel[i]));
                end
                for (int i = 0; i < 3; i++) begin
                    rate_sum[i] += longint'($signed(smp.rate[i]));
                end
                avg_count++;
            end else if (!in_startup && avg_count < gra_pkg::HOLD_COUNT) begin
                avg_count++;
            end else begin
                latch = 1'b1;
            end
        end
        // latch averages, floor rounding for the signed ones, clamp the gyro sums
        if (latch) begin
            held_refs.pressure = 24'(pres_sum >> gra_pkg::AVG_SHIFT);
            for (int i = 0; i < 4; i++) begin
                held_refs.accel[i] = 16'(accel_sum[i] >>> gra_pkg::AVG_SHIFT);
                accel_sum[i] = 0;
            end
            for (int i = 0; i < 3; i++) begin
                clamped = rate_sum[i];
                if (clamped > longint'(gra_pkg::RATE_MAX)) begin
                    clamped = longint'(gra_pkg::RATE_MAX);
                end else if (clamped < longint'(gra_pkg::RATE_MIN)) begin
                    clamped = longint'(gra_pkg::RATE_MIN);
                end
                held_refs.rate[i] = 25'(clamped);
                rate_sum[i] = 0;
            end
            pres_sum   = 0;
            avg_count  = 0;
            in_startup = 1'b0;
            latch_total++;
        end
        r         = held_refs;
        r.started = !in_startup;
        r.updated = latch;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (err_count < 40) begin
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        err_count++;
    endtask

    // idling phases: none, sender idle, receiver stalling, both
    function automatic void set_phase(input int k);
        case (k % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 33; stall_pct = 33; end
        endcase
    endfunction

    function automatic bit [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic sensor_sample_t rand_sample(input bit pad);
        sensor_sample_t smp;
        case ($urandom_range(0, 7))
            0: smp.pressure = 24'h000000;
            1: smp.pressure = 24'hFFFFFF;
            default: smp.pressure = 24'($urandom());
        endcase
        for (int i = 0; i < 4; i++) begin
            smp.accel[i] = pick_word();
        end
        for (int i = 0; i < 3; i++) begin
            smp.rate[i] = pick_word();
        end
        smp.on_pad = pad;
        return smp;
    endfunction

    // offer one sample, wait for the request to be taken, then predict it
    task automatic send_sample(input sensor_sample_t smp);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {smp.rate, smp.accel, smp.pressure};
        s_tuser  <= smp.on_pad;
        do @(posedge aclk); while (!s_tready);
        refs_q.push_back(predict_refs(smp));
    endtask

    // sender pauses until every expected result has come
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (refs_q.size() != 0);
    endtask

    // receiver: random stalls plus a counted long hold-off on request
    always @(posedge aclk) begin : drive_ready
        int hold_left;
        if (hold_off_req > 0) begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin : check_results
        ground_refs_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (refs_q.size() == 0) begin
                flag_mismatch("result with nothing expected", 32'(m_tuser), 32'd0);
            end else begin
                want = refs_q.pop_front();
                if (m_tuser[0] !== want.started) begin
                    flag_mismatch("ready_res", 32'(m_tuser[0]), 32'(want.started));
                end
                if (m_tuser[1] !== want.updated) begin
                    flag_mismatch("refs_updated", 32'(m_tuser[1]), 32'(want.updated));
                end
                if (m_tdata[23:0] !== want.pressure) begin
                    flag_mismatch("ground_pressure", 32'(m_tdata[23:0]), 32'(want.pressure));
                end
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[24 + 16*i +: 16] !== want.accel[i]) begin
                        flag_mismatch(accel_name[i], 32'(m_tdata[24 + 16*i +: 16]),
                                      32'(want.accel[i]));
                    end
                end
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[88 + 25*i +: 25] !== want.rate[i]) begin
                        flag_mismatch(rate_name[i], 32'(m_tdata[88 + 25*i +: 25]),
                                      32'(want.rate[i]));
                    end
                end
            end
        end
    end

    // field extremes and bit patterns at the start of startup, on_pad toggling
    task automatic test_directed_corners();
        sensor_sample_t smp;
        bit [23:0] pres_pat [8] = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                                    24'h555555, 24'hAAAAAA, 24'h000001, 24'hFFFFFE};
        bit [15:0] word_pat [8] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                    16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE};
        set_phase(0);
        for (int k = 0; k < 20; k++) begin
            smp.pressure = pres_pat[k % 8];
            for (int i = 0; i < 4; i++) begin
                smp.accel[i] = word_pat[(k + i) % 8];
            end
            for (int i = 0; i < 3; i++) begin
                smp.rate[i] = word_pat[(k + 4 + i) % 8];
            end
            smp.on_pad = (k % 2) != 0;
            send_sample(smp);
        end
        wait_drain();
    endtask

    // finish the startup window with random samples until the first latch
    task automatic test_startup_window();
        int n;
        n = 0;
        while (in_startup) begin
            if (n % 64 == 0) begin
                set_phase(n / 64);
            end
            send_sample(rand_sample(1'($urandom_range(0, 1))));
            n++;
        end
        wait_drain();
    endtask

    // on-pad window of full-scale samples: widest pressure sum, lowest signed sums
    task automatic test_full_scale_window();
        sensor_sample_t smp;
        int             base;
        int             n;
        base = latch_total;
        n    = 0;
        while (latch_total == base) begin
            if (n % 64 == 0) begin
                set_phase(n / 64);
            end
            smp = rand_sample(1'b1);
            if (avg_count < gra_pkg::SUM_COUNT) begin
                smp.pressure = 24'hFFFFFF;
                smp.accel    = {4{16'h8000}};
                smp.rate     = {3{16'h8000}};
            end
            send_sample(smp);
            n++;
        end
        wait_drain();
    endtask

    // random on-pad summing with liftoff glitches that freeze the sums
    task automatic test_pad_reaverage();
        for (int n = 0; n < 160; n++) begin
            if (n % 40 == 0) begin
                set_phase(n / 40 + 1);
            end
            send_sample(rand_sample($urandom_range(0, 9) != 0));
        end
        wait_drain();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_receiver_hold();
        set_phase(0);
        hold_off_req = 300;
        for (int k = 0; k < 40; k++) begin
            send_sample(rand_sample(1'b1));
        end
        wait_drain();
    endtask

    // after liftoff the references and counter stay frozen
    task automatic test_liftoff();
        for (int k = 0; k < 100; k++) begin
            if (k % 32 == 0) begin
                set_phase(k / 32);
            end
            send_sample(rand_sample(1'b0));
        end
        wait_drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_corners();
        test_startup_window();
        test_full_scale_window();
        test_pad_reaverage();
        test_receiver_hold();
        test_liftoff();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
